>>> design/wllo_pkg.sv
package wllo_pkg;

	localparam int SAMPLE_BITS_DEFAULT = 16;
	localparam int WIN_BITS            = 16;
	localparam int OPACITY_BITS        = 9;
	localparam int CHAN_BITS           = 8;
	localparam int LABEL_BITS          = 2;
	localparam int CFG_INDEX_BITS      = 3;
	localparam int CFG_DATA_BITS       = 16;

	localparam int NUM_BITS      = 32;
	localparam int DEN_BITS      = 16;
	localparam int QUOT_BITS     = 16;
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_STAGES    = QUOT_BITS / DIV_STEP_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MIN       = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MAX       = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_OPACITY          = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOW_CLASS_ONE   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOW_CLASS_TWO   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOW_CLASS_THREE = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERLAY_ENABLE   = 3'd6;

	localparam logic signed [WIN_BITS-1:0] WINDOW_MIN_RESET = 16'sd0;
	localparam logic signed [WIN_BITS-1:0] WINDOW_MAX_RESET = 16'sd4095;
	localparam logic [OPACITY_BITS-1:0]    OPACITY_RESET    = 9'd128;
	localparam logic [OPACITY_BITS-1:0]    OPACITY_FULL     = 9'd256;

	localparam logic [LABEL_BITS-1:0] LABEL_CLASS_ONE   = 2'd1;
	localparam logic [LABEL_BITS-1:0] LABEL_CLASS_TWO   = 2'd2;
	localparam logic [LABEL_BITS-1:0] LABEL_CLASS_THREE = 2'd3;

	localparam logic [CHAN_BITS-1:0] CLASS_RED   [4] = '{8'd0, 8'd255, 8'd60, 8'd255};
	localparam logic [CHAN_BITS-1:0] CLASS_GREEN [4] = '{8'd0, 8'd60, 8'd220, 8'd220};
	localparam logic [CHAN_BITS-1:0] CLASS_BLUE  [4] = '{8'd0, 8'd60, 8'd60, 8'd40};

	typedef struct packed {
		logic                  show;
		logic [LABEL_BITS-1:0] label;
	} pix_side_t;

endpackage

>>> design/wllo_div.sv
module wllo_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [wllo_pkg::NUM_BITS-1:0]  num,
	input  logic [wllo_pkg::DEN_BITS-1:0]  den,
	input  wllo_pkg::pix_side_t            in_side,
	output logic                           out_valid,
	output logic [wllo_pkg::QUOT_BITS-1:0] quot,
	output wllo_pkg::pix_side_t            out_side
);
	import wllo_pkg::*;

	function automatic logic [DEN_BITS+DIV_STEP_BITS-1:0] div_steps(
		input logic [DEN_BITS-1:0]      r,
		input logic [DIV_STEP_BITS-1:0] nb,
		input logic [DEN_BITS-1:0]      d
	);
		logic [DEN_BITS:0]        t;
		logic [DEN_BITS-1:0]      rr;
		logic [DIV_STEP_BITS-1:0] q;
		rr = r;
		q  = '0;
		for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
			t = {rr, nb[i]};
			if (t >= {1'b0, d}) begin
				t    = t - {1'b0, d};
				q[i] = 1'b1;
			end
			rr = t[DEN_BITS-1:0];
		end
		return {rr, q};
	endfunction

	logic [DEN_BITS-1:0]  rem_s  [DIV_STAGES];
	logic [QUOT_BITS-1:0] low_s  [DIV_STAGES];
	logic [QUOT_BITS-1:0] quot_s [DIV_STAGES];
	logic                 vld_s  [DIV_STAGES];
	pix_side_t            side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DEN_BITS-1:0]               rem_in;
		logic [QUOT_BITS-1:0]              low_in;
		logic [QUOT_BITS-1:0]              quot_in;
		logic                              vld_in;
		pix_side_t                         side_in;
		logic [DEN_BITS+DIV_STEP_BITS-1:0] step;

		if (k == 0) begin : g_first
			assign rem_in  = num[NUM_BITS-1 -: DEN_BITS];
			assign low_in  = num[QUOT_BITS-1:0];
			assign quot_in = '0;
			assign vld_in  = in_valid;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign low_in  = low_s[k-1];
			assign quot_in = quot_s[k-1];
			assign vld_in  = vld_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign step = div_steps(rem_in, low_in[QUOT_BITS-1 -: DIV_STEP_BITS], den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= step[DEN_BITS+DIV_STEP_BITS-1 -: DEN_BITS];
			low_s[k]  <= low_in << DIV_STEP_BITS;
			quot_s[k] <= {quot_in[QUOT_BITS-DIV_STEP_BITS-1:0], step[DIV_STEP_BITS-1:0]};
			side_s[k] <= side_in;
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quot      = quot_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

>>> design/window_level_label_overlay.sv
// Window/level gray mapping with a coloured class overlay, one pixel per clock.
// Input channel: drive sample and label with start high; the pixel transfers
// at any rising edge where start is high and busy is low. busy stays low, so
// a new pixel may be offered in every cycle.
// Result channel: gray_out, red_out, green_out and blue_out are valid for one
// cycle while done is high. Throughput is 1 pixel/cycle. The pipeline stages
// are clamp, scale, four divider stages of four quotient bits each, blend
// multiply, blend sum and clamp. The receiver cannot stall; results leave in
// input order with no back-pressure. Configuration: cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. The user must write
// registers only while no pixel is in flight; the block does not enforce
// this. Reset (arst_n low) clears every pipeline valid bit and loads the
// register defaults: window 0..4095, opacity 128, all classes shown, overlay
// off.
module window_level_label_overlay #(
	parameter int SAMPLE_BITS = wllo_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic [wllo_pkg::LABEL_BITS-1:0]     label,
	output logic                                done,
	output logic [wllo_pkg::CHAN_BITS-1:0]      gray_out,
	output logic [wllo_pkg::CHAN_BITS-1:0]      red_out,
	output logic [wllo_pkg::CHAN_BITS-1:0]      green_out,
	output logic [wllo_pkg::CHAN_BITS-1:0]      blue_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wllo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [wllo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import wllo_pkg::*;

	localparam int EXT_BITS = ((SAMPLE_BITS > WIN_BITS) ? SAMPLE_BITS : WIN_BITS) + 1;
	localparam int PROD_BITS = QUOT_BITS + OPACITY_BITS;
	localparam int COL_BITS  = CHAN_BITS + OPACITY_BITS;
	localparam int ACC_BITS  = PROD_BITS + 1;

	logic signed [WIN_BITS-1:0] win_min_q;
	logic signed [WIN_BITS-1:0] win_max_q;
	logic [OPACITY_BITS-1:0]    opacity_q;
	logic                       show_one_q;
	logic                       show_two_q;
	logic                       show_three_q;
	logic                       overlay_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_q    <= WINDOW_MIN_RESET;
			win_max_q    <= WINDOW_MAX_RESET;
			opacity_q    <= OPACITY_RESET;
			show_one_q   <= 1'b1;
			show_two_q   <= 1'b1;
			show_three_q <= 1'b1;
			overlay_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_MIN:       win_min_q    <= cfg_data[WIN_BITS-1:0];
				CFG_WINDOW_MAX:       win_max_q    <= cfg_data[WIN_BITS-1:0];
				CFG_OPACITY:          opacity_q    <= cfg_data[OPACITY_BITS-1:0];
				CFG_SHOW_CLASS_ONE:   show_one_q   <= cfg_data[0];
				CFG_SHOW_CLASS_TWO:   show_two_q   <= cfg_data[0];
				CFG_SHOW_CLASS_THREE: show_three_q <= cfg_data[0];
				CFG_OVERLAY_ENABLE:   overlay_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// window clamp and offset
	logic                       accept;
	logic signed [EXT_BITS-1:0] v_x;
	logic signed [EXT_BITS-1:0] min_x;
	logic signed [EXT_BITS-1:0] max_x;
	logic signed [EXT_BITS-1:0] off_x;
	logic signed [WIN_BITS:0]   range_x;
	logic                       empty;
	logic [DEN_BITS-1:0]        den;
	logic [DEN_BITS-1:0]        d_next;
	logic                       show_next;

	assign accept  = start && !busy;
	assign v_x     = EXT_BITS'(sample);
	assign min_x   = EXT_BITS'(win_min_q);
	assign max_x   = EXT_BITS'(win_max_q);
	assign off_x   = v_x - min_x;
	assign range_x = (WIN_BITS + 1)'(win_max_q) - (WIN_BITS + 1)'(win_min_q);
	assign empty   = (win_max_q <= win_min_q);
	assign den     = empty ? DEN_BITS'(1) : range_x[DEN_BITS-1:0];

	always_comb begin
		if (empty || v_x <= min_x) begin
			d_next = '0;
		end else if (v_x >= max_x) begin
			d_next = range_x[DEN_BITS-1:0];
		end else begin
			d_next = off_x[DEN_BITS-1:0];
		end
	end

	assign show_next = overlay_q &&
		((label == LABEL_CLASS_ONE   && show_one_q) ||
		 (label == LABEL_CLASS_TWO   && show_two_q) ||
		 (label == LABEL_CLASS_THREE && show_three_q));

	logic                vld_s1;
	logic [DEN_BITS-1:0] d_s1;
	pix_side_t           side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		d_s1          <= d_next;
		side_s1.show  <= show_next;
		side_s1.label <= label;
	end

	// scale by 255 * 256: d * 65536 - d * 256
	logic                vld_s2;
	logic [NUM_BITS-1:0] num_s2;
	pix_side_t           side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2  <= {d_s1, 16'h0000} - {8'h00, d_s1, 8'h00};
		side_s2 <= side_s1;
	end

	logic                 div_vld;
	logic [QUOT_BITS-1:0] div_quot;
	pix_side_t            div_side;

	wllo_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.num       (num_s2),
		.den       (den),
		.in_side   (side_s2),
		.out_valid (div_vld),
		.quot      (div_quot),
		.out_side  (div_side)
	);

	// blend products
	logic [OPACITY_BITS-1:0] o_sat;
	logic [OPACITY_BITS-1:0] o_inv;

	assign o_sat = (opacity_q > OPACITY_FULL) ? OPACITY_FULL : opacity_q;
	assign o_inv = OPACITY_FULL - o_sat;

	logic                 vld_s7;
	logic                 show_s7;
	logic [CHAN_BITS-1:0] gray_s7;
	logic [PROD_BITS-1:0] prod_s7;
	logic [COL_BITS-1:0]  red_s7;
	logic [COL_BITS-1:0]  green_s7;
	logic [COL_BITS-1:0]  blue_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		show_s7  <= div_side.show;
		gray_s7  <= div_quot[QUOT_BITS-1 -: CHAN_BITS];
		prod_s7  <= PROD_BITS'(div_quot) * PROD_BITS'(o_inv);
		red_s7   <= COL_BITS'(CLASS_RED[div_side.label]) * COL_BITS'(o_sat);
		green_s7 <= COL_BITS'(CLASS_GREEN[div_side.label]) * COL_BITS'(o_sat);
		blue_s7  <= COL_BITS'(CLASS_BLUE[div_side.label]) * COL_BITS'(o_sat);
	end

	// blend sum, truncate and clamp
	function automatic logic [CHAN_BITS-1:0] blend_sum(
		input logic [PROD_BITS-1:0] p,
		input logic [COL_BITS-1:0]  c
	);
		logic [ACC_BITS-1:0] acc;
		logic [ACC_BITS-17:0] res;
		acc = ACC_BITS'(p) + ACC_BITS'({c, 8'h00});
		res = acc[ACC_BITS-1:16];
		return (res > (ACC_BITS - 16)'(255)) ? 8'hFF : res[CHAN_BITS-1:0];
	endfunction

	logic                 vld_s8;
	logic [CHAN_BITS-1:0] gray_s8;
	logic [CHAN_BITS-1:0] red_s8;
	logic [CHAN_BITS-1:0] green_s8;
	logic [CHAN_BITS-1:0] blue_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		gray_s8 <= gray_s7;
		if (show_s7) begin
			red_s8   <= blend_sum(prod_s7, red_s7);
			green_s8 <= blend_sum(prod_s7, green_s7);
			blue_s8  <= blend_sum(prod_s7, blue_s7);
		end else begin
			red_s8   <= gray_s7;
			green_s8 <= gray_s7;
			blue_s8  <= gray_s7;
		end
	end

	assign done      = vld_s8;
	assign gray_out  = gray_s8;
	assign red_out   = red_s8;
	assign green_out = green_s8;
	assign blue_out  = blue_s8;

endmodule

>>> bench/window_level_label_overlay_test.sv
`timescale 1ns / 100ps

module window_level_label_overlay_test;
	import wllo_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 13;
	localparam int PER_PHASE   = 100;

	localparam logic [7:0] TINT_RED   [4] = '{8'd0, 8'd255, 8'd60, 8'd255};
	localparam logic [7:0] TINT_GREEN [4] = '{8'd0, 8'd60, 8'd220, 8'd220};
	localparam logic [7:0] TINT_BLUE  [4] = '{8'd0, 8'd60, 8'd60, 8'd40};

	typedef struct packed {
		logic [7:0] gray;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		logic [CFG_INDEX_BITS-1:0]   index;
		logic [CFG_DATA_BITS-1:0]    value;
		logic signed [15:0]          smp;
		logic [LABEL_BITS-1:0]       lab;
		bit                          typed;
		shade_t                      want;
	} plan_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic signed [15:0]          sample;
	logic [LABEL_BITS-1:0]       label;
	logic                        done;
	logic [CHAN_BITS-1:0]        gray_out;
	logic [CHAN_BITS-1:0]        red_out;
	logic [CHAN_BITS-1:0]        green_out;
	logic [CHAN_BITS-1:0]        blue_out;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;

	logic signed [15:0]          win_lo   = 16'sd0;
	logic signed [15:0]          win_hi   = 16'sd4095;
	logic [OPACITY_BITS-1:0]     opac     = 9'd128;
	bit [3:0]                    show_cls = 4'b1110;
	bit                          ovl_en   = 1'b0;

	shade_t    shade_q[$];
	plan_row_t plan[$];
	int        mismatches = 0;
	int        sent       = 0;
	int        results    = 0;
	int        writes     = 0;
	int        cycles     = 0;

	window_level_label_overlay u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.label     (label),
		.done      (done),
		.gray_out  (gray_out),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, shade_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] blend_chan(longint g, longint o, longint c);
		longint acc;
		acc = (g * (256 - o) + c * 256 * o) >>> 16;
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	function automatic shade_t overlay_pixel(logic signed [15:0] s, logic [LABEL_BITS-1:0] lab);
		longint lo;
		longint hi;
		longint v;
		longint span;
		longint d;
		longint g;
		longint o;
		shade_t r;
		lo = win_lo;
		hi = win_hi;
		v  = s;
		if (hi <= lo || v <= lo) begin
			span = 1;
			d    = 0;
		end else begin
			span = hi - lo;
			d    = (v >= hi) ? span : v - lo;
		end
		g = (d * 65280) / span;
		o = (opac > OPACITY_FULL) ? longint'(OPACITY_FULL) : longint'(opac);
		r.gray = 8'(g >>> 8);
		if (ovl_en && show_cls[lab]) begin
			r.red   = blend_chan(g, o, TINT_RED[lab]);
			r.green = blend_chan(g, o, TINT_GREEN[lab]);
			r.blue  = blend_chan(g, o, TINT_BLUE[lab]);
		end else begin
			r.red   = r.gray;
			r.green = r.gray;
			r.blue  = r.gray;
		end
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx, int val);
		plan_row_t r;
		r.kind  = ROW_CFG;
		r.index = idx;
		r.value = val[15:0];
		r.smp   = '0;
		r.lab   = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic plan_row_t pix_row(int s, int lab);
		plan_row_t r;
		r.kind  = ROW_PIX;
		r.index = '0;
		r.value = '0;
		r.smp   = s[15:0];
		r.lab   = lab[LABEL_BITS-1:0];
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic plan_row_t pix_row_exp(int s, int lab, shade_t want);
		plan_row_t r;
		r       = pix_row(s, lab);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		shade_t want;
		if (arst_n && done) begin
			if (shade_q.size() == 0) begin
				$error("result with no pixel outstanding: gray %0d", gray_out);
				mismatches++;
			end else begin
				want = shade_q.pop_front();
				check_chan("gray_out", want.gray, gray_out);
				check_chan("red_out", want.red, red_out);
				check_chan("green_out", want.green, green_out);
				check_chan("blue_out", want.blue, blue_out);
				results++;
			end
		end
	end

	task automatic drain();
		start <= 1'b0;
		while (shade_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_WINDOW_MIN:       win_lo = val;
			CFG_WINDOW_MAX:       win_hi = val;
			CFG_OPACITY:          opac = val[OPACITY_BITS-1:0];
			CFG_SHOW_CLASS_ONE:   show_cls[1] = val[0];
			CFG_SHOW_CLASS_TWO:   show_cls[2] = val[0];
			CFG_SHOW_CLASS_THREE: show_cls[3] = val[0];
			CFG_OVERLAY_ENABLE:   ovl_en = val[0];
			default: ;
		endcase
		writes++;
	endtask

	task automatic send_pixel(logic signed [15:0] s, logic [LABEL_BITS-1:0] lab, int gap,
			bit typed, shade_t want);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		sample <= s;
		label  <= lab;
		do
			@(posedge clk);
		while (busy);
		shade_q.push_back(typed ? want : overlay_pixel(s, lab));
		sent++;
	endtask

	function automatic int draw_gap(bit burst);
		if (burst || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	initial begin
		int  lo;
		int  hi;
		int  v;
		int  op;
		bit  burst;
		logic signed [15:0] s;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		sample    <= '0;
		label     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;

		plan.push_back(pix_row_exp(-32768, 0, '{8'd0, 8'd0, 8'd0, 8'd0}));
		plan.push_back(pix_row_exp(0, 1, '{8'd0, 8'd0, 8'd0, 8'd0}));
		plan.push_back(pix_row_exp(4095, 2, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(pix_row_exp(32767, 3, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(pix_row(1000, 1));
		plan.push_back(cfg_row(CFG_OVERLAY_ENABLE, 1));
		plan.push_back(pix_row_exp(0, 0, '{8'd0, 8'd0, 8'd0, 8'd0}));
		plan.push_back(pix_row(2000, 1));
		plan.push_back(pix_row(2000, 2));
		plan.push_back(pix_row(2000, 3));
		plan.push_back(cfg_row(CFG_OPACITY, 256));
		plan.push_back(pix_row_exp(0, 1, '{8'd0, 8'd255, 8'd60, 8'd60}));
		plan.push_back(pix_row_exp(0, 2, '{8'd0, 8'd60, 8'd220, 8'd60}));
		plan.push_back(pix_row_exp(0, 3, '{8'd0, 8'd255, 8'd220, 8'd40}));
		plan.push_back(cfg_row(CFG_OPACITY, 0));
		plan.push_back(pix_row_exp(4095, 3, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(cfg_row(CFG_OPACITY, 511));
		plan.push_back(pix_row_exp(32767, 2, '{8'd255, 8'd60, 8'd220, 8'd60}));
		plan.push_back(cfg_row(CFG_SHOW_CLASS_ONE, 0));
		plan.push_back(cfg_row(CFG_SHOW_CLASS_TWO, 0));
		plan.push_back(cfg_row(CFG_SHOW_CLASS_THREE, 0));
		plan.push_back(pix_row_exp(4095, 1, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(pix_row_exp(4095, 2, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(pix_row_exp(4095, 3, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(cfg_row(CFG_SHOW_CLASS_ONE, 1));
		plan.push_back(cfg_row(CFG_SHOW_CLASS_TWO, 1));
		plan.push_back(cfg_row(CFG_SHOW_CLASS_THREE, 1));
		plan.push_back(cfg_row(CFG_WINDOW_MIN, -32768));
		plan.push_back(cfg_row(CFG_WINDOW_MAX, 32767));
		plan.push_back(cfg_row(CFG_OPACITY, 100));
		plan.push_back(pix_row(-32768, 1));
		plan.push_back(pix_row(32767, 2));
		plan.push_back(pix_row(0, 3));
		plan.push_back(cfg_row(CFG_WINDOW_MIN, 100));
		plan.push_back(cfg_row(CFG_WINDOW_MAX, 100));
		plan.push_back(pix_row_exp(32767, 0, '{8'd0, 8'd0, 8'd0, 8'd0}));
		plan.push_back(pix_row_exp(-5, 0, '{8'd0, 8'd0, 8'd0, 8'd0}));
		plan.push_back(cfg_row(CFG_WINDOW_MAX, -100));
		plan.push_back(pix_row_exp(50, 0, '{8'd0, 8'd0, 8'd0, 8'd0}));
		plan.push_back(pix_row(50, 1));
		plan.push_back(cfg_row(CFG_WINDOW_MIN, -32768));
		plan.push_back(cfg_row(CFG_WINDOW_MAX, -32767));
		plan.push_back(pix_row_exp(-32767, 0, '{8'd255, 8'd255, 8'd255, 8'd255}));
		plan.push_back(pix_row_exp(-32768, 0, '{8'd0, 8'd0, 8'd0, 8'd0}));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].index, plan[i].value);
			end else begin
				send_pixel(plan[i].smp, plan[i].lab, draw_gap(1'b0), plan[i].typed,
					plan[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: begin
					lo = -32768;
					hi = 32767;
				end
				1: begin
					lo = int'($urandom_range(0, 65535)) - 32768;
					hi = lo + int'($urandom_range(1, 300));
				end
				2: begin
					lo = int'($urandom_range(0, 65535)) - 32768;
					hi = int'($urandom_range(0, 65535)) - 32768;
				end
				3: begin
					lo = int'($urandom_range(0, 2048)) - 1024;
					hi = lo + int'($urandom_range(1, 4096));
				end
				4: begin
					lo = int'($urandom_range(0, 65535)) - 32768;
					hi = lo;
				end
				default: begin
					hi = 32767;
					lo = hi - int'($urandom_range(1, 65535));
				end
			endcase
			if (hi > 32767)
				hi = 32767;
			case ($urandom_range(0, 4))
				0:       op = 0;
				1:       op = 256;
				2:       op = $urandom_range(257, 511);
				default: op = $urandom_range(0, 256);
			endcase

			drain();
			write_reg(CFG_WINDOW_MIN, lo[15:0]);
			write_reg(CFG_WINDOW_MAX, hi[15:0]);
			write_reg(CFG_OPACITY, op[15:0]);
			write_reg(CFG_SHOW_CLASS_ONE, 16'($urandom_range(0, 3) != 0));
			write_reg(CFG_SHOW_CLASS_TWO, 16'($urandom_range(0, 3) != 0));
			write_reg(CFG_SHOW_CLASS_THREE, 16'($urandom_range(0, 3) != 0));
			write_reg(CFG_OVERLAY_ENABLE, 16'($urandom_range(0, 3) != 0));

			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PER_PHASE; k++) begin
				if (hi > lo && $urandom_range(0, 3) != 0) begin
					v = lo - 8 + int'($urandom_range(0, hi - lo + 16));
					if (v < -32768)
						v = -32768;
					if (v > 32767)
						v = 32767;
					s = v[15:0];
				end else begin
					s = 16'($urandom_range(0, 65535));
				end
				send_pixel(s, 2'($urandom_range(0, 3)), draw_gap(burst), 1'b0, '0);
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("%0d pixels sent, %0d results checked, %0d register writes across %0d settings",
			sent, results, writes, PHASES + 1);
		$display("windows from empty to full range, opacity 0..511, all label/class combinations");
		if (mismatches == 0 && shade_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> files.f
design/wllo_pkg.sv
design/wllo_div.sv
design/window_level_label_overlay.sv
bench/window_level_label_overlay_test.sv
